### rtl/fas_pkg.sv
// ----------------------------------------------------------------------------
// fas_pkg: shared types and constants of the arming supervisor
// Item and result structures, command, mode and register codes, and the
// fixed constants of the throttle ramp arithmetic.
// ----------------------------------------------------------------------------
package fas_pkg;

    typedef struct packed {
        logic        [2:0]  cmd;
        logic        [31:0] now_ms;
        logic signed [15:0] roll_centideg;
        logic signed [15:0] pitch_centideg;
        logic               imu_healthy;
        logic               battery_crit_now;
        logic        [2:0]  mode_request;
        logic        [15:0] battery_mv;
        logic        [15:0] step_ms;
    } t_in;

    typedef struct packed {
        logic [2:0]  mode_now;
        logic        is_armed;
        logic [16:0] throttle_scale_q16;
        logic        warn_flag;
        logic        crit_flag;
        logic        arm_pending;
    } t_out;

    typedef struct packed {
        logic prod;
        logic split;
        logic scale;
    } t_ramp_ld;

    localparam logic [2:0] CMD_UPDATE  = 3'd0;
    localparam logic [2:0] CMD_ARM     = 3'd1;
    localparam logic [2:0] CMD_DISARM  = 3'd2;
    localparam logic [2:0] CMD_SETMODE = 3'd3;
    localparam logic [2:0] CMD_BATTERY = 3'd4;
    localparam logic [2:0] CMD_RAMP    = 3'd5;

    localparam logic [2:0] MODE_DISARMED    = 3'd0;
    localparam logic [2:0] MODE_CALIBRATING = 3'd1;
    localparam logic [2:0] MODE_READY       = 3'd2;
    localparam logic [2:0] MODE_ARMED       = 3'd3;
    localparam logic [2:0] MODE_FAILSAFE    = 3'd4;

    localparam logic [2:0] REG_MAX_TILT     = 3'd0;
    localparam logic [2:0] REG_IMU_TIMEOUT  = 3'd1;
    localparam logic [2:0] REG_BATT_ENABLE  = 3'd2;
    localparam logic [2:0] REG_SETTLE_TIME  = 3'd3;
    localparam logic [2:0] REG_ARM_HOLD     = 3'd4;
    localparam logic [2:0] REG_BATT_CRIT    = 3'd5;
    localparam logic [2:0] REG_BATT_WARN    = 3'd6;
    localparam logic [2:0] REG_RAMP_RATE    = 3'd7;

    localparam logic [14:0]        RST_MAX_TILT    = 15'd3000;
    localparam logic [31:0]        RST_IMU_TIMEOUT = 32'd100;
    localparam logic [31:0]        RST_SETTLE_TIME = 32'd500;
    localparam logic [31:0]        RST_ARM_HOLD    = 32'd1000;
    localparam logic signed [21:0] RST_RAMP_RATE   = 22'sd65536;

    localparam logic [16:0] SCALE_ONE = 17'd65536;

    // Product magnitude from which the quotient by 1000 reaches full scale.
    localparam logic [37:0] RAMP_SAT_PRODUCT = 38'd65536000;
    // ceil(2^30 / 125): exact floor division by 125 for operands below 2^23.
    localparam logic [23:0] DIV125_RECIP     = 24'd8589935;
    localparam int          DIV125_SHIFT     = 30;

endpackage

### rtl/flight_arming_safety_supervisor.sv
// ----------------------------------------------------------------------------
// flight_arming_safety_supervisor: arming and failsafe supervisor
// Tracks the flight mode, arm requests, IMU health, battery latches and a
// Q16 throttle ramp, and returns one result for every command item.
// ----------------------------------------------------------------------------
// Usage: command items enter on i_valid/o_ready with payload i_item, and
// one result per item leaves on o_valid/i_ready with payload o_result, in
// order. A transaction completes when valid and ready are both high.
// Configuration registers are written through i_cfg_valid/o_cfg_ready with
// i_cfg_index and i_cfg_data; the port is always ready and should only be
// used while no item is in flight.
// Pipeline: an accepted item passes through four item stages (three of them
// carry the ramp multiply and the division by 1000), the last of which loads
// the result register. Throughput is one item per cycle while the receiver
// does not stall; the state is updated as the item leaves the last stage.
// Reset restores the register defaults, the disarmed mode and empty stages.
// When the receiver stalls, the result register holds and the stages keep
// filling; o_ready falls only once every stage is occupied.
// ----------------------------------------------------------------------------
module flight_arming_safety_supervisor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  fas_pkg::t_in  i_item,
    output logic          o_valid,
    input  logic          i_ready,
    output fas_pkg::t_out o_result,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    logic [14:0]        r_max_tilt;
    logic [31:0]        r_imu_timeout;
    logic               r_batt_en;
    logic [31:0]        r_settle_time;
    logic [31:0]        r_arm_hold;
    logic [15:0]        r_batt_crit;
    logic [15:0]        r_batt_warn;
    logic signed [21:0] r_ramp_rate;

    logic [3:0]   r_v;
    fas_pkg::t_in r_item [4];
    logic [3:0]   w_ld;
    logic [3:0]   w_adv;
    logic [3:0]   w_free;
    logic         w_out_free;

    logic          r_out_v;
    fas_pkg::t_out r_out;

    logic [2:0]  r_mode;
    logic        r_arm_flag;
    logic [31:0] r_arm_time;
    logic [31:0] r_ready_time;
    logic [31:0] r_imu_time;
    logic        r_warn;
    logic        r_crit;
    logic [16:0] r_ramp;

    logic [2:0]  n_mode;
    logic        n_arm_flag;
    logic [31:0] n_arm_time;
    logic [31:0] n_ready_time;
    logic [31:0] n_imu_time;
    logic        n_warn;
    logic        n_crit;
    logic [16:0] n_ramp;
    fas_pkg::t_out n_out;

    fas_pkg::t_ramp_ld  w_ramp_ld;
    logic signed [17:0] w_delta;
    fas_pkg::t_in       w_cur;
    logic [16:0]        w_roll_mag;
    logic [16:0]        w_pitch_mag;
    logic signed [16:0] w_roll_x;
    logic signed [16:0] w_pitch_x;
    logic signed [16:0] w_roll_n;
    logic signed [16:0] w_pitch_n;
    logic signed [18:0] w_sum;

    assign w_cur = r_item[3];

    always_comb begin
        w_out_free = !r_out_v || i_ready;
        w_adv[3]   = r_v[3] && w_out_free;
        w_free[3]  = !r_v[3] || w_adv[3];
        for (int k = 2; k >= 0; k--) begin
            w_adv[k]  = r_v[k] && w_free[k + 1];
            w_free[k] = !r_v[k] || w_adv[k];
        end
        w_ld[0] = i_valid && w_free[0];
        for (int k = 1; k < 4; k++) begin
            w_ld[k] = w_adv[k - 1];
        end
    end

    assign o_ready     = w_free[0];
    assign o_valid     = r_out_v;
    assign o_result    = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_ramp_ld.prod  = w_ld[1];
    assign w_ramp_ld.split = w_ld[2];
    assign w_ramp_ld.scale = w_ld[3];

    fas_ramp_delta u_ramp_delta (
        .i_clk   (i_clk),
        .i_ld    (w_ramp_ld),
        .i_rate  (r_ramp_rate),
        .i_step  (r_item[0].step_ms),
        .o_delta (w_delta)
    );

    assign w_roll_x    = {w_cur.roll_centideg[15], w_cur.roll_centideg};
    assign w_pitch_x   = {w_cur.pitch_centideg[15], w_cur.pitch_centideg};
    assign w_roll_n    = -w_roll_x;
    assign w_pitch_n   = -w_pitch_x;
    assign w_roll_mag  = w_roll_x[16] ? w_roll_n : w_roll_x;
    assign w_pitch_mag = w_pitch_x[16] ? w_pitch_n : w_pitch_x;
    assign w_sum       = $signed({2'b00, r_ramp}) + $signed({w_delta[17], w_delta});

    always_comb begin
        n_mode       = r_mode;
        n_arm_flag   = r_arm_flag;
        n_arm_time   = r_arm_time;
        n_ready_time = r_ready_time;
        n_imu_time   = r_imu_time;
        n_warn       = r_warn;
        n_crit       = r_crit;
        n_ramp       = r_ramp;
        case (w_cur.cmd)
            fas_pkg::CMD_UPDATE: begin
                if (w_cur.imu_healthy) begin
                    n_imu_time = w_cur.now_ms;
                end
                if ((w_roll_mag > {2'b00, r_max_tilt}) ||
                    (w_pitch_mag > {2'b00, r_max_tilt}) ||
                    ((w_cur.now_ms - n_imu_time) > r_imu_timeout) ||
                    (r_batt_en && w_cur.battery_crit_now)) begin
                    n_mode     = fas_pkg::MODE_FAILSAFE;
                    n_arm_flag = 1'b0;
                    n_ramp     = '0;
                end
                if (n_mode == fas_pkg::MODE_READY) begin
                    if (r_arm_flag &&
                        ((w_cur.now_ms - r_ready_time) >= r_settle_time)) begin
                        if ((w_cur.now_ms - r_arm_time) >= r_arm_hold) begin
                            n_mode = fas_pkg::MODE_ARMED;
                            n_ramp = '0;
                        end
                    end else if (!r_arm_flag) begin
                        n_arm_time = w_cur.now_ms;
                    end
                end
            end
            fas_pkg::CMD_ARM: begin
                if (!r_arm_flag) begin
                    n_arm_flag = 1'b1;
                    n_arm_time = w_cur.now_ms;
                end
            end
            fas_pkg::CMD_DISARM: begin
                n_mode     = fas_pkg::MODE_DISARMED;
                n_arm_flag = 1'b0;
                n_ramp     = '0;
            end
            fas_pkg::CMD_SETMODE: begin
                if (w_cur.mode_request <= fas_pkg::MODE_FAILSAFE) begin
                    n_mode = w_cur.mode_request;
                    if (w_cur.mode_request == fas_pkg::MODE_READY) begin
                        n_ready_time = w_cur.now_ms;
                    end
                    if (w_cur.mode_request == fas_pkg::MODE_ARMED) begin
                        n_ramp = '0;
                    end
                    if ((w_cur.mode_request == fas_pkg::MODE_DISARMED) ||
                        (w_cur.mode_request == fas_pkg::MODE_FAILSAFE)) begin
                        n_arm_flag = 1'b0;
                        n_ramp     = '0;
                    end
                end
            end
            fas_pkg::CMD_BATTERY: begin
                if (r_batt_en) begin
                    if (w_cur.battery_mv <= r_batt_crit) begin
                        n_crit = 1'b1;
                    end
                    if (w_cur.battery_mv <= r_batt_warn) begin
                        n_warn = 1'b1;
                    end
                end
            end
            fas_pkg::CMD_RAMP: begin
                if (r_mode == fas_pkg::MODE_ARMED) begin
                    if (w_sum < 0) begin
                        n_ramp = '0;
                    end else if (w_sum > $signed({2'b00, fas_pkg::SCALE_ONE})) begin
                        n_ramp = fas_pkg::SCALE_ONE;
                    end else begin
                        n_ramp = w_sum[16:0];
                    end
                end
            end
            default: begin
            end
        endcase

        n_out.mode_now           = n_mode;
        n_out.is_armed           = (n_mode == fas_pkg::MODE_ARMED);
        n_out.throttle_scale_q16 = (n_mode == fas_pkg::MODE_ARMED) ? n_ramp : '0;
        n_out.warn_flag          = n_warn;
        n_out.crit_flag          = n_crit;
        n_out.arm_pending        = n_arm_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tilt    <= fas_pkg::RST_MAX_TILT;
            r_imu_timeout <= fas_pkg::RST_IMU_TIMEOUT;
            r_batt_en     <= 1'b0;
            r_settle_time <= fas_pkg::RST_SETTLE_TIME;
            r_arm_hold    <= fas_pkg::RST_ARM_HOLD;
            r_batt_crit   <= '0;
            r_batt_warn   <= '0;
            r_ramp_rate   <= fas_pkg::RST_RAMP_RATE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fas_pkg::REG_MAX_TILT:    r_max_tilt    <= i_cfg_data[14:0];
                fas_pkg::REG_IMU_TIMEOUT: r_imu_timeout <= i_cfg_data;
                fas_pkg::REG_BATT_ENABLE: r_batt_en     <= i_cfg_data[0];
                fas_pkg::REG_SETTLE_TIME: r_settle_time <= i_cfg_data;
                fas_pkg::REG_ARM_HOLD:    r_arm_hold    <= i_cfg_data;
                fas_pkg::REG_BATT_CRIT:   r_batt_crit   <= i_cfg_data[15:0];
                fas_pkg::REG_BATT_WARN:   r_batt_warn   <= i_cfg_data[15:0];
                fas_pkg::REG_RAMP_RATE:   r_ramp_rate   <= $signed(i_cfg_data[21:0]);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v     <= '0;
            r_out_v <= 1'b0;
        end else begin
            for (int k = 0; k < 4; k++) begin
                r_v[k] <= w_ld[k] || (r_v[k] && !w_adv[k]);
            end
            if (w_adv[3]) begin
                r_out_v <= 1'b1;
            end else if (i_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld[0]) begin
            r_item[0] <= i_item;
        end
        for (int k = 1; k < 4; k++) begin
            if (w_ld[k]) begin
                r_item[k] <= r_item[k - 1];
            end
        end
        if (w_adv[3]) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= fas_pkg::MODE_DISARMED;
            r_arm_flag   <= 1'b0;
            r_arm_time   <= '0;
            r_ready_time <= '0;
            r_imu_time   <= '0;
            r_warn       <= 1'b0;
            r_crit       <= 1'b0;
            r_ramp       <= '0;
        end else if (w_adv[3]) begin
            r_mode       <= n_mode;
            r_arm_flag   <= n_arm_flag;
            r_arm_time   <= n_arm_time;
            r_ready_time <= n_ready_time;
            r_imu_time   <= n_imu_time;
            r_warn       <= n_warn;
            r_crit       <= n_crit;
            r_ramp       <= n_ramp;
        end
    end

    a_throttle_only_armed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out.is_armed) |-> (r_out.throttle_scale_q16 == '0))
        else $error("throttle scale non-zero outside armed mode");

    a_ramp_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ramp <= fas_pkg::SCALE_ONE)
        else $error("ramp value beyond full scale");

    a_warn_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_warn))
        else $error("battery warning latch cleared");

    a_crit_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_crit))
        else $error("battery critical latch cleared");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && !$past(w_adv[3])) |-> ($stable(r_mode) && $stable(r_ramp)))
        else $error("supervisor state changed without a transaction");

endmodule

### rtl/fas_ramp_delta.sv
// ----------------------------------------------------------------------------
// fas_ramp_delta: throttle ramp increment pipeline
// Forms rate times step, divides by 1000 with truncation toward zero by a
// reciprocal multiplication, and clamps the magnitude at full scale.
// ----------------------------------------------------------------------------
module fas_ramp_delta (
    input  logic               i_clk,
    input  fas_pkg::t_ramp_ld  i_ld,
    input  logic signed [21:0] i_rate,
    input  logic        [15:0] i_step,
    output logic signed [17:0] o_delta
);

    logic signed [38:0] r_prod;
    logic               r_neg;
    logic               r_big;
    logic        [22:0] r_y;
    logic               r_neg_q;
    logic               r_big_q;
    logic        [46:0] r_qm;

    logic signed [38:0] w_prod_neg;
    logic        [37:0] w_abs;
    logic               w_big;
    logic        [16:0] w_q;
    logic        [17:0] w_mag;

    assign w_prod_neg = -r_prod;
    assign w_abs      = r_prod[38] ? w_prod_neg[37:0] : r_prod[37:0];
    assign w_big      = w_abs >= fas_pkg::RAMP_SAT_PRODUCT;

    assign w_q     = r_qm[fas_pkg::DIV125_SHIFT +: 17];
    assign w_mag   = r_big_q ? {1'b0, fas_pkg::SCALE_ONE} : {1'b0, w_q};
    assign o_delta = r_neg_q ? -$signed(w_mag) : $signed(w_mag);

    always_ff @(posedge i_clk) begin
        if (i_ld.prod) begin
            r_prod <= i_rate * $signed({1'b0, i_step});
        end
        if (i_ld.split) begin
            r_neg <= r_prod[38];
            r_big <= w_big;
            r_y   <= w_abs[25:3];
        end
        if (i_ld.scale) begin
            r_neg_q <= r_neg;
            r_big_q <= r_big;
            r_qm    <= {24'd0, r_y} * {23'd0, fas_pkg::DIV125_RECIP};
        end
    end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the flight arming safety supervisor
// Commands are queued by a stimulus process and sent by a clocked driver with
// random gaps; a clocked monitor steps a behavioural copy of the supervisor on
// every accepted command transaction and compares each returned status
// transaction, field by field, with the oldest status still awaited. The run
// covers the reset settings, both extremes of the registers and random ones.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    localparam logic [2:0] CMD_UNUSED_LO   = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI   = 3'd7;
    localparam logic [2:0] MODE_UNUSED     = 3'd5;
    localparam logic [2:0] MODE_UNUSED_TOP = 3'd7;
    localparam int         DRAIN_CYCLES    = 12;

    logic          i_clk       = 1'b0;
    logic          i_rst_n     = 1'b0;
    logic          i_valid     = 1'b0;
    logic          o_ready;
    fas_pkg::t_in  i_item      = '0;
    logic          o_valid;
    logic          i_ready     = 1'b0;
    fas_pkg::t_out o_result;
    logic          i_cfg_valid = 1'b0;
    logic          o_cfg_ready;
    logic [2:0]    i_cfg_index = '0;
    logic [31:0]   i_cfg_data  = '0;

    flight_arming_safety_supervisor dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Register copy.
    logic [14:0] lim_tilt     = fas_pkg::RST_MAX_TILT;
    logic [31:0] lim_imu_ms   = fas_pkg::RST_IMU_TIMEOUT;
    bit          batt_en      = 1'b0;
    logic [31:0] lim_settle   = fas_pkg::RST_SETTLE_TIME;
    logic [31:0] lim_hold     = fas_pkg::RST_ARM_HOLD;
    logic [15:0] batt_crit_mv = '0;
    logic [15:0] batt_warn_mv = '0;
    int          ramp_rate    = fas_pkg::RST_RAMP_RATE;

    // Supervisor state copy.
    logic [2:0]  sv_mode    = fas_pkg::MODE_DISARMED;
    bit          sv_arm_req = 1'b0;
    logic [31:0] sv_arm_t   = '0;
    logic [31:0] sv_ready_t = '0;
    logic [31:0] sv_imu_t   = '0;
    bit          sv_warn    = 1'b0;
    bit          sv_crit    = 1'b0;
    int          sv_ramp    = 0;

    fas_pkg::t_in  command_q[$];
    fas_pkg::t_out status_q[$];
    int          queued        = 0;
    bit          mismatch_seen = 1'b0;
    bit          in_fire       = 1'b0;
    bit          out_fire      = 1'b0;
    int          gap_left      = 0;
    int          calm_in       = 0;
    int          stall_left    = 0;
    int          calm_out      = 0;
    logic [31:0] clock_ms      = '0;
    int          pace_hi       = 20;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic void switch_mode(logic [2:0] m, logic [31:0] now);
        sv_mode = m;
        if (m == fas_pkg::MODE_READY) sv_ready_t = now;
        if (m == fas_pkg::MODE_ARMED) sv_ramp = 0;
        if (m == fas_pkg::MODE_DISARMED || m == fas_pkg::MODE_FAILSAFE) begin
            sv_arm_req = 1'b0;
            sv_ramp    = 0;
        end
    endfunction

    function automatic fas_pkg::t_out advance_supervisor(fas_pkg::t_in it);
        fas_pkg::t_out r;
        int          roll_mag;
        int          pitch_mag;
        logic [31:0] since;
        longint      delta;
        longint      level;
        roll_mag  = $signed(it.roll_centideg);
        pitch_mag = $signed(it.pitch_centideg);
        if (roll_mag < 0) roll_mag = -roll_mag;
        if (pitch_mag < 0) pitch_mag = -pitch_mag;
        case (it.cmd)
            fas_pkg::CMD_UPDATE: begin
                if (it.imu_healthy) sv_imu_t = it.now_ms;
                if (roll_mag > int'(lim_tilt) || pitch_mag > int'(lim_tilt))
                    switch_mode(fas_pkg::MODE_FAILSAFE, it.now_ms);
                since = it.now_ms - sv_imu_t;
                if (since > lim_imu_ms) switch_mode(fas_pkg::MODE_FAILSAFE, it.now_ms);
                if (batt_en && it.battery_crit_now)
                    switch_mode(fas_pkg::MODE_FAILSAFE, it.now_ms);
                if (sv_mode == fas_pkg::MODE_READY) begin
                    since = it.now_ms - sv_ready_t;
                    if (sv_arm_req && since >= lim_settle) begin
                        since = it.now_ms - sv_arm_t;
                        if (since >= lim_hold) switch_mode(fas_pkg::MODE_ARMED, it.now_ms);
                    end else if (!sv_arm_req) begin
                        sv_arm_t = it.now_ms;
                    end
                end
            end
            fas_pkg::CMD_ARM: begin
                if (!sv_arm_req) begin
                    sv_arm_req = 1'b1;
                    sv_arm_t   = it.now_ms;
                end
            end
            fas_pkg::CMD_DISARM: switch_mode(fas_pkg::MODE_DISARMED, it.now_ms);
            fas_pkg::CMD_SETMODE: begin
                if (it.mode_request <= fas_pkg::MODE_FAILSAFE)
                    switch_mode(it.mode_request, it.now_ms);
            end
            fas_pkg::CMD_BATTERY: begin
                if (batt_en) begin
                    if (it.battery_mv <= batt_crit_mv) sv_crit = 1'b1;
                    if (it.battery_mv <= batt_warn_mv) sv_warn = 1'b1;
                end
            end
            fas_pkg::CMD_RAMP: begin
                if (sv_mode == fas_pkg::MODE_ARMED) begin
                    delta = (longint'(ramp_rate) * longint'(it.step_ms)) / 1000;
                    level = longint'(sv_ramp) + delta;
                    if (level < 0) level = 0;
                    if (level > longint'(fas_pkg::SCALE_ONE))
                        level = longint'(fas_pkg::SCALE_ONE);
                    sv_ramp = int'(level);
                end
            end
            default: ;
        endcase
        r.mode_now           = sv_mode;
        r.is_armed           = (sv_mode == fas_pkg::MODE_ARMED);
        r.throttle_scale_q16 = (sv_mode == fas_pkg::MODE_ARMED) ? sv_ramp[16:0] : '0;
        r.warn_flag          = sv_warn;
        r.crit_flag          = sv_crit;
        r.arm_pending        = sv_arm_req;
        return r;
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            fas_pkg::REG_MAX_TILT:    lim_tilt     = data[14:0];
            fas_pkg::REG_IMU_TIMEOUT: lim_imu_ms   = data;
            fas_pkg::REG_BATT_ENABLE: batt_en      = data[0];
            fas_pkg::REG_SETTLE_TIME: lim_settle   = data;
            fas_pkg::REG_ARM_HOLD:    lim_hold     = data;
            fas_pkg::REG_BATT_CRIT:   batt_crit_mv = data[15:0];
            fas_pkg::REG_BATT_WARN:   batt_warn_mv = data[15:0];
            fas_pkg::REG_RAMP_RATE:   ramp_rate    = $signed(data[21:0]);
            default: ;
        endcase
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_seen = 1'b1;
        end
    endfunction

    function automatic int draw_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Prediction and checking, both on the rising edge.
    always @(posedge i_clk) begin
        fas_pkg::t_out want;
        in_fire  = i_rst_n && i_valid && o_ready;
        out_fire = i_rst_n && o_valid && i_ready;
        if (out_fire) begin
            if (status_q.size() == 0) begin
                $error("status transaction with none awaited: mode_now %0d",
                       o_result.mode_now);
                mismatch_seen = 1'b1;
            end else begin
                want = status_q.pop_front();
                check_field("mode_now", 32'(want.mode_now), 32'(o_result.mode_now));
                check_field("is_armed", 32'(want.is_armed), 32'(o_result.is_armed));
                check_field("throttle_scale_q16", 32'(want.throttle_scale_q16),
                            32'(o_result.throttle_scale_q16));
                check_field("warn_flag", 32'(want.warn_flag), 32'(o_result.warn_flag));
                check_field("crit_flag", 32'(want.crit_flag), 32'(o_result.crit_flag));
                check_field("arm_pending", 32'(want.arm_pending), 32'(o_result.arm_pending));
            end
        end
        if (in_fire) status_q.push_back(advance_supervisor(i_item));
    end

    always @(negedge i_clk) begin
        logic         send;
        fas_pkg::t_in item;
        send = i_valid;
        item = i_item;
        if (!i_rst_n) begin
            send = 1'b0;
        end else if (!i_valid || in_fire) begin
            if (in_fire) begin
                if (calm_in > 0) calm_in--;
                else if ($urandom_range(0, 39) == 0) calm_in = $urandom_range(30, 150);
                else gap_left = draw_idle();
            end
            if (gap_left > 0) begin
                gap_left--;
                send = 1'b0;
            end else if (command_q.size() != 0) begin
                item = command_q.pop_front();
                send = 1'b1;
            end else begin
                send = 1'b0;
            end
        end
        i_valid <= send;
        i_item  <= item;
    end

    always @(negedge i_clk) begin
        if (stall_left == 0 && (out_fire || $urandom_range(0, 19) == 0)) begin
            if (calm_out > 0) calm_out--;
            else if ($urandom_range(0, 39) == 0) calm_out = $urandom_range(30, 150);
            else stall_left = draw_idle();
        end
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    function automatic fas_pkg::t_in mk(logic [2:0] cmd, logic [31:0] t);
        logic [127:0] noise;
        fas_pkg::t_in it;
        noise     = {$urandom, $urandom, $urandom, $urandom};
        it        = noise[$bits(fas_pkg::t_in)-1:0];
        it.cmd    = cmd;
        it.now_ms = t;
        return it;
    endfunction

    function automatic void push(fas_pkg::t_in it);
        command_q.push_back(it);
        queued++;
    endfunction

    function automatic void push_cmd(logic [2:0] cmd, logic [31:0] t);
        push(mk(cmd, t));
    endfunction

    function automatic void push_upd(logic [31:0] t, bit ok, bit crit, int roll, int pitch);
        fas_pkg::t_in it;
        it                  = mk(fas_pkg::CMD_UPDATE, t);
        it.imu_healthy      = ok;
        it.battery_crit_now = crit;
        it.roll_centideg    = roll[15:0];
        it.pitch_centideg   = pitch[15:0];
        push(it);
    endfunction

    function automatic void push_mode(logic [31:0] t, logic [2:0] m);
        fas_pkg::t_in it;
        it              = mk(fas_pkg::CMD_SETMODE, t);
        it.mode_request = m;
        push(it);
    endfunction

    function automatic void push_batt(logic [31:0] t, logic [15:0] mv);
        fas_pkg::t_in it;
        it            = mk(fas_pkg::CMD_BATTERY, t);
        it.battery_mv = mv;
        push(it);
    endfunction

    function automatic void push_ramp(logic [31:0] t, logic [15:0] ms);
        fas_pkg::t_in it;
        it         = mk(fas_pkg::CMD_RAMP, t);
        it.step_ms = ms;
        push(it);
    endfunction

    function automatic int calm_tilt();
        int span;
        span = int'(lim_tilt);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [15:0] probe_mv();
        int v;
        if ($urandom_range(0, 4) == 0) return 16'($urandom);
        v = ($urandom_range(0, 1) != 0) ? int'(batt_crit_mv) : int'(batt_warn_mv);
        v = v + int'($urandom_range(0, 400)) - 200;
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_ramp_ms();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        if (r < 3) return 16'($urandom_range(0, 3000));
        return 16'($urandom_range(0, 300));
    endfunction

    function automatic void tick();
        clock_ms += $urandom_range(0, pace_hi);
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_limits(int tilt, logic [31:0] tmo, bit en, logic [31:0] settle,
                              logic [31:0] hold, int crit, int warn, int rate);
        write_reg(fas_pkg::REG_MAX_TILT, 32'(tilt));
        write_reg(fas_pkg::REG_IMU_TIMEOUT, tmo);
        write_reg(fas_pkg::REG_BATT_ENABLE, 32'(en));
        write_reg(fas_pkg::REG_SETTLE_TIME, settle);
        write_reg(fas_pkg::REG_ARM_HOLD, hold);
        write_reg(fas_pkg::REG_BATT_CRIT, 32'(crit));
        write_reg(fas_pkg::REG_BATT_WARN, 32'(warn));
        write_reg(fas_pkg::REG_RAMP_RATE, 32'(rate));
        if (lim_imu_ms == 0) pace_hi = 3;
        else if (lim_imu_ms > 40) pace_hi = 40;
        else pace_hi = int'(lim_imu_ms);
    endtask

    task automatic wait_drained();
        while (command_q.size() != 0 || i_valid || status_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic void queue_noise(int n);
        repeat (n) begin
            if ($urandom_range(0, 7) == 0) clock_ms = $urandom;
            else tick();
            push(mk(3'($urandom_range(0, 7)), clock_ms));
        end
    endfunction

    // A typical flight: set armed mode directly, or bring the supervisor to ready,
    // request arming and send IMU updates; then ramp the throttle, then end it somehow.
    function automatic void queue_flight();
        int tilt_hit;
        tick();
        if ($urandom_range(0, 2) == 0) push_cmd(fas_pkg::CMD_DISARM, clock_ms);
        if ($urandom_range(0, 3) == 0) begin
            push_upd(clock_ms, 1'b1, 1'b0, calm_tilt(), calm_tilt());
            push_mode(clock_ms, fas_pkg::MODE_ARMED);
        end else begin
            if ($urandom_range(0, 2) == 0) push_mode(clock_ms, fas_pkg::MODE_CALIBRATING);
            push_upd(clock_ms, 1'b1, 1'b0, calm_tilt(), calm_tilt());
            push_mode(clock_ms, fas_pkg::MODE_READY);
            if ($urandom_range(0, 1) != 0) begin
                tick();
                push_upd(clock_ms, 1'b1, 1'b0, calm_tilt(), calm_tilt());
            end
            push_cmd(fas_pkg::CMD_ARM, clock_ms);
            repeat ($urandom_range(3, 18)) begin
                tick();
                if ($urandom_range(0, 7) == 0) push_cmd(fas_pkg::CMD_ARM, clock_ms);
                push_upd(clock_ms, $urandom_range(0, 11) != 0, $urandom_range(0, 24) == 0,
                         calm_tilt(), calm_tilt());
            end
        end
        repeat ($urandom_range(3, 12)) begin
            case ($urandom_range(0, 4))
                0, 1: push_ramp(clock_ms, pick_ramp_ms());
                2: begin
                    tick();
                    push_upd(clock_ms, 1'b1, 1'b0, calm_tilt(), calm_tilt());
                end
                3: push_batt(clock_ms, probe_mv());
                default: push_ramp(clock_ms, pick_ramp_ms());
            endcase
        end
        case ($urandom_range(0, 5))
            0: push_cmd(fas_pkg::CMD_DISARM, clock_ms);
            1: push_mode(clock_ms, fas_pkg::MODE_FAILSAFE);
            2: begin
                tilt_hit = int'(lim_tilt) + 1 + int'($urandom_range(0, 2000));
                if (tilt_hit > 32767) tilt_hit = 32767;
                if ($urandom_range(0, 1) != 0) tilt_hit = -tilt_hit;
                if ($urandom_range(0, 1) != 0)
                    push_upd(clock_ms, 1'b1, 1'b0, calm_tilt(), tilt_hit);
                else
                    push_upd(clock_ms, 1'b1, 1'b0, tilt_hit, calm_tilt());
            end
            3: begin
                clock_ms += $urandom_range(50, 400);
                push_upd(clock_ms, 1'b0, 1'b0, calm_tilt(), calm_tilt());
            end
            4: push_upd(clock_ms, 1'b1, 1'b1, calm_tilt(), calm_tilt());
            default: ;
        endcase
    endfunction

    function automatic void queue_phase(int quota);
        int stop;
        stop = queued + quota;
        while (queued < stop) begin
            if ($urandom_range(0, 3) == 0) queue_noise($urandom_range(1, 5));
            else queue_flight();
        end
    endfunction

    initial begin
        int crit_r;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: battery checks are off, so neither flag may latch.
        push_upd(0, 1'b1, 1'b1, 0, 0);
        push_batt(0, 16'd0);
        push_cmd(CMD_UNUSED_LO, 0);
        push_cmd(CMD_UNUSED_HI, 0);
        push_mode(0, MODE_UNUSED);
        wait_drained();

        set_limits(3000, 100, 1'b1, 50, 80, 10500, 11100, 65536);
        push_upd(0, 1'b1, 1'b0, 0, 0);
        push_mode(10, fas_pkg::MODE_READY);
        push_cmd(fas_pkg::CMD_ARM, 20);
        push_cmd(fas_pkg::CMD_ARM, 40);
        push_upd(70, 1'b1, 1'b0, 3000, -3000);
        push_upd(100, 1'b1, 1'b0, 0, 0);
        push_ramp(100, 16'd0);
        push_ramp(100, 16'd500);
        push_ramp(100, 16'hFFFF);
        push_batt(100, 16'd11101);
        push_batt(100, 16'd11100);
        push_batt(100, 16'd10501);
        push_upd(150, 1'b1, 1'b0, -32768, 0);
        push_ramp(150, 16'd1000);
        push_mode(160, fas_pkg::MODE_ARMED);
        push_ramp(160, 16'd250);
        push_upd(400, 1'b0, 1'b0, 0, 0);
        push_mode(410, fas_pkg::MODE_READY);
        push_upd(420, 1'b1, 1'b1, 0, 0);
        push_batt(420, 16'd10500);
        push_cmd(fas_pkg::CMD_DISARM, 430);
        push_mode(430, fas_pkg::MODE_CALIBRATING);
        push_mode(430, MODE_UNUSED_TOP);
        // Arming across the wrap of the millisecond counter.
        push_mode(32'hFFFF_FFF0, fas_pkg::MODE_READY);
        push_upd(32'hFFFF_FFF0, 1'b1, 1'b0, 0, 0);
        push_cmd(fas_pkg::CMD_ARM, 32'hFFFF_FFF8);
        push_upd(32'h0000_0010, 1'b1, 1'b0, 0, 0);
        push_upd(32'h0000_0060, 1'b1, 1'b0, 0, 0);
        clock_ms = 32'h0000_0100;
        queue_phase(200);
        wait_drained();

        set_limits(0, 0, 1'b1, 0, 0, 0, 65535, -1048576);
        queue_phase(200);
        wait_drained();

        set_limits(18000, 32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 65535, 0, 1048576);
        queue_phase(200);
        wait_drained();

        repeat (2) begin
            crit_r = $urandom_range(9000, 11000);
            set_limits($urandom_range(500, 18000), $urandom_range(30, 300), 1'b1,
                       $urandom_range(0, 100), $urandom_range(0, 150), crit_r,
                       crit_r + int'($urandom_range(0, 1500)),
                       int'($urandom_range(0, 2097152)) - 1048576);
            queue_phase(200);
            wait_drained();
        end

        if (!mismatch_seen) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
